@@ sv/vfvp_pkg.sv @@
// Package: shared types, constants and the face corner table of the vertex packer.
`default_nettype none
package vfvp_pkg;

    localparam int BASE_INDEX_WIDTH = 20;
    localparam int BASE_OUT_W       = 20;
    localparam int ATLAS_W          = 8;
    localparam int ATLAS_RESET      = 16;
    localparam int FQ_DEPTH         = 2;
    localparam int FQ_AW            = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CW            = $clog2(FQ_DEPTH + 1);
    localparam int CORNERS          = 4;

    typedef enum logic [2:0] {
        FACE_FRONT  = 3'd0,
        FACE_BACK   = 3'd1,
        FACE_LEFT   = 3'd2,
        FACE_RIGHT  = 3'd3,
        FACE_TOP    = 3'd4,
        FACE_BOTTOM = 3'd5,
        FACE_BAD6   = 3'd6,
        FACE_BAD7   = 3'd7
    } t_face;

    typedef struct packed {
        logic dx;
        logic dy;
        logic dz;
        logic u;
        logic v;
    } t_corner;

    typedef struct packed {
        logic [4:0]                  bx;
        logic [4:0]                  by;
        logic [8:0]                  bz;
        t_face                       face;
        logic [CORNERS-1:0][1:0]     ao;
        logic                        flip;
        logic [7:0]                  tex;
        logic [BASE_INDEX_WIDTH-1:0] base;
    } t_face_rec;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fq_ctl;

    function automatic t_corner corner_of(t_face face, logic [1:0] vn);
        t_corner c;
        c = '0;
        unique case (face)
            FACE_FRONT: begin
                unique case (vn)
                    2'd0: c = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
                    2'd2: c = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
                    default: c = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
                endcase
            end
            FACE_BACK: begin
                unique case (vn)
                    2'd0: c = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
                    2'd2: c = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
                    default: c = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
                endcase
            end
            FACE_LEFT: begin
                unique case (vn)
                    2'd0: c = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
                    2'd2: c = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
                    default: c = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
                endcase
            end
            FACE_RIGHT: begin
                unique case (vn)
                    2'd0: c = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
                    2'd2: c = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
                    default: c = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
                endcase
            end
            FACE_TOP: begin
                unique case (vn)
                    2'd0: c = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
                    2'd2: c = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
                    default: c = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
                endcase
            end
            FACE_BOTTOM: begin
                unique case (vn)
                    2'd0: c = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
                    2'd2: c = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
                    default: c = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ sv/vfvp_front.sv @@
// Front end: accepts faces, computes occlusion, texture index and base index, drops bad faces.
`default_nettype none
module vfvp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [vfvp_pkg::ATLAS_W-1:0]  i_cfg_data,
    input  wire logic                          i_accept,
    input  wire logic                          i_restart,
    input  wire logic [4:0]                    i_block_x,
    input  wire logic [4:0]                    i_block_y,
    input  wire logic [8:0]                    i_block_z,
    input  wire logic [2:0]                    i_face,
    input  wire logic [11:0]                   i_neighbor_solid,
    input  wire logic [7:0]                    i_tex_col,
    input  wire logic [7:0]                    i_tex_row,
    output logic                               o_push,
    output vfvp_pkg::t_face_rec                o_rec
);

    logic [vfvp_pkg::ATLAS_W-1:0]          r_atlas_width;
    logic [vfvp_pkg::BASE_INDEX_WIDTH-1:0] r_count;
    logic [vfvp_pkg::BASE_INDEX_WIDTH-1:0] n_count;
    logic [vfvp_pkg::BASE_INDEX_WIDTH-1:0] base;
    logic [15:0]                           prod;
    logic [vfvp_pkg::CORNERS-1:0][1:0]     ao;
    logic [2:0]                            diag_a;
    logic [2:0]                            diag_b;
    logic                                  face_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_width <= vfvp_pkg::ATLAS_W'(vfvp_pkg::ATLAS_RESET);
            r_count       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_atlas_width <= i_cfg_data;
            end
            r_count <= n_count;
        end
    end

    always_comb begin
        for (int v = 0; v < vfvp_pkg::CORNERS; v++) begin
            logic s1, s2, c;
            s1 = i_neighbor_solid[3*v];
            s2 = i_neighbor_solid[3*v+1];
            c  = i_neighbor_solid[3*v+2];
            if (s1 && s2) begin
                ao[v] = 2'd0;
            end else begin
                ao[v] = 2'(2'd3 - ({1'b0, s1} + {1'b0, s2} + {1'b0, c}));
            end
        end
    end

    assign diag_a  = {1'b0, ao[0]} + {1'b0, ao[3]};
    assign diag_b  = {1'b0, ao[1]} + {1'b0, ao[2]};
    assign face_ok = (i_face <= 3'(vfvp_pkg::FACE_BOTTOM));
    assign base    = i_restart ? '0 : r_count;
    assign prod    = i_tex_col * r_atlas_width;

    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            n_count = face_ok ? vfvp_pkg::BASE_INDEX_WIDTH'(base + 3'd4) : base;
        end
    end

    assign o_push     = i_accept && face_ok;
    assign o_rec.bx   = i_block_x;
    assign o_rec.by   = i_block_y;
    assign o_rec.bz   = i_block_z;
    assign o_rec.face = vfvp_pkg::t_face'(i_face);
    assign o_rec.ao   = ao;
    assign o_rec.flip = (diag_a > diag_b);
    assign o_rec.tex  = 8'(prod[7:0] + i_tex_row);
    assign o_rec.base = base;

endmodule
`default_nettype wire

@@ sv/vfvp_fifo.sv @@
// Face queue between the front end and the vertex sequencer.
`default_nettype none
module vfvp_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire vfvp_pkg::t_fq_ctl    i_ctl,
    input  wire vfvp_pkg::t_face_rec  i_rec,
    output vfvp_pkg::t_face_rec       o_rec,
    output logic                      o_full,
    output logic                      o_empty
);

    vfvp_pkg::t_face_rec             r_mem [vfvp_pkg::FQ_DEPTH];
    logic [vfvp_pkg::FQ_AW-1:0]      r_wptr;
    logic [vfvp_pkg::FQ_AW-1:0]      r_rptr;
    logic [vfvp_pkg::FQ_CW-1:0]      r_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_cnt == vfvp_pkg::FQ_CW'(vfvp_pkg::FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_ctl.push && !o_full;
    assign do_pop  = i_ctl.pop && !o_empty;
    assign o_rec   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == vfvp_pkg::FQ_AW'(vfvp_pkg::FQ_DEPTH - 1)) ?
                          '0 : vfvp_pkg::FQ_AW'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == vfvp_pkg::FQ_AW'(vfvp_pkg::FQ_DEPTH - 1)) ?
                          '0 : vfvp_pkg::FQ_AW'(r_rptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= vfvp_pkg::FQ_CW'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= vfvp_pkg::FQ_CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/vfvp_back.sv @@
// Back end: steps through the four corners of the held face and forms each vertex word.
`default_nettype none
module vfvp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire vfvp_pkg::t_face_rec           i_rec,
    input  wire logic                          i_q_empty,
    output logic                               o_q_pop,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [31:0]                        o_vertex_word,
    output logic [1:0]                         o_vertex_number,
    output logic [vfvp_pkg::BASE_OUT_W-1:0]    o_base_index,
    output logic                               o_quad_flipped,
    output logic                               o_last
);

    vfvp_pkg::t_face_rec r_rec;
    logic                r_valid;
    logic [1:0]          r_vn;
    logic                take;
    logic                load;
    vfvp_pkg::t_corner   cor;
    logic [4:0]          x;
    logic [4:0]          y;
    logic [8:0]          z;
    logic [31:0]         base_ext;

    assign take    = r_valid && i_pop;
    assign load    = (!r_valid || (take && r_vn == 2'd3)) && !i_q_empty;
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vn    <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_vn    <= '0;
            end else if (take) begin
                r_vn <= 2'(r_vn + 1'b1);
                if (r_vn == 2'd3) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    assign cor      = vfvp_pkg::corner_of(r_rec.face, r_vn);
    assign x        = 5'(r_rec.bx + {4'd0, cor.dx});
    assign y        = 5'(r_rec.by + {4'd0, cor.dy});
    assign z        = 9'(r_rec.bz + {8'd0, cor.dz});
    assign base_ext = 32'(r_rec.base);

    assign o_empty         = !r_valid;
    assign o_vertex_word   = {x, y, z, 1'b0, r_rec.ao[r_vn], cor.u, cor.v, r_rec.tex};
    assign o_vertex_number = r_vn;
    assign o_base_index    = base_ext[vfvp_pkg::BASE_OUT_W-1:0];
    assign o_quad_flipped  = r_rec.flip;
    assign o_last          = (r_vn == 2'd3);

endmodule
`default_nettype wire

@@ sv/voxel_face_vertex_packer.sv @@
// Top level: voxel face vertex packer, front end, face queue and vertex sequencer.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------
//  face in  | push / full              | restart, block_x/y/z, face, neighbor_solid,
//           |                          | tex_col, tex_row
//  vertex   | empty / pop              | vertex_word, vertex_number, base_index,
//           |                          | quad_flipped, last
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_data (atlas_width)
//
// A face is taken on push while full is low; its four vertices leave one per cycle
// while pop is held, so the single result channel sets the sustained rate. First
// vertex follows the queue write and sequencer load. A two-entry face queue lets
// the front keep taking faces while the output stalls; full rises when it fills.
// Face codes 6 and 7 produce no transaction. Synchronous reset clears counters.
`default_nettype none
module voxel_face_vertex_packer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [vfvp_pkg::ATLAS_W-1:0]  i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_restart,
    input  wire logic [4:0]                    i_block_x,
    input  wire logic [4:0]                    i_block_y,
    input  wire logic [8:0]                    i_block_z,
    input  wire logic [2:0]                    i_face,
    input  wire logic [11:0]                   i_neighbor_solid,
    input  wire logic [7:0]                    i_tex_col,
    input  wire logic [7:0]                    i_tex_row,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [31:0]                        o_vertex_word,
    output logic [1:0]                         o_vertex_number,
    output logic [vfvp_pkg::BASE_OUT_W-1:0]    o_base_index,
    output logic                               o_quad_flipped,
    output logic                               o_last
);

    vfvp_pkg::t_face_rec front_rec;
    vfvp_pkg::t_face_rec q_rec;
    vfvp_pkg::t_fq_ctl   q_ctl;
    logic                front_push;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic                accept;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;
    assign q_ctl.push  = front_push;
    assign q_ctl.pop   = q_pop;

    vfvp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_restart        (i_restart),
        .i_block_x        (i_block_x),
        .i_block_y        (i_block_y),
        .i_block_z        (i_block_z),
        .i_face           (i_face),
        .i_neighbor_solid (i_neighbor_solid),
        .i_tex_col        (i_tex_col),
        .i_tex_row        (i_tex_row),
        .o_push           (front_push),
        .o_rec            (front_rec)
    );

    vfvp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_rec   (front_rec),
        .o_rec   (q_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    vfvp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec           (q_rec),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_vertex_word   (o_vertex_word),
        .o_vertex_number (o_vertex_number),
        .o_base_index    (o_base_index),
        .o_quad_flipped  (o_quad_flipped),
        .o_last          (o_last)
    );

    a_corner_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) |=>
            (!empty && o_vertex_number == 2'($past(o_vertex_number) + 1'b1)))
        else $error("corner number did not advance within a face");

    a_base_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) |=>
            (o_base_index == $past(o_base_index) && o_quad_flipped == $past(o_quad_flipped)))
        else $error("face attributes changed between corners");

    a_first_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last) |=> (empty || o_vertex_number == 2'd0))
        else $error("new face did not start at corner zero");

    a_queue_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !q_empty) |=> !empty)
        else $error("sequencer idle while a face waits in the queue");

endmodule
`default_nettype wire
